@@ hdl/mzs_pkg.sv @@
package mzs_pkg;

	localparam int unsigned Z_BITS        = 16;
	localparam int unsigned WLEN_BITS     = 11;
	localparam int unsigned EPS_BITS      = 24;
	localparam int unsigned CFG_IDX_BITS  = 1;
	localparam int unsigned CFG_DATA_BITS = 24;
	localparam int unsigned Z_FRAC_BITS   = 10;
	localparam int unsigned EPS_SCALE_BITS = 8;

	localparam logic signed [Z_BITS-1:0] Z_POS_MAX = 16'sh7fff;
	localparam logic signed [Z_BITS-1:0] Z_NEG_MAX = 16'sh8000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WINDOW_LENGTH = 1'b0,
		REG_EPSILON       = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLEAR,
		OP_START,
		OP_SQUARE,
		OP_UPDATE,
		OP_MA_INIT,
		OP_MA_STEP,
		OP_MB_INIT,
		OP_MB_STEP,
		OP_SQ_INIT,
		OP_SQ_STEP,
		OP_PROD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

endpackage

@@ hdl/moving_zscore_unit.sv @@
// Moving-window z-score of signed samples.
// One request in flight: a sample or clear is accepted only while the sequencer is
// idle; bit-serial multiply, square root and divide steps compute each score, and
// the finished result waits while an earlier one is still untaken.
// Reset: asynchronous, active low; empties the window, restores registers.
module moving_zscore_unit #(
	parameter int unsigned WINDOW_MAX  = 1024,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave side: tdata = sample, tuser = cmd (1 clears)
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [8*((SAMPLE_BITS+7)/8)-1:0]      s_axis_tdata,   // [SB-1:0] sample
	input  logic                                  s_axis_tuser,   // [0] cmd
	// master side
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [mzs_pkg::Z_BITS-1:0]            m_axis_tdata,   // [15:0] z_score
	output logic                                  m_axis_tuser,   // [0] window_full
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mzs_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [mzs_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int unsigned CW       = $clog2(WINDOW_MAX + 1);
	localparam int unsigned SW       = SAMPLE_BITS + CW;
	localparam int unsigned NW       = SW + 1 + mzs_pkg::Z_FRAC_BITS;
	localparam int unsigned IW       = $clog2(NW + 1);

	logic [mzs_pkg::WLEN_BITS-1:0] wlen_q;
	logic [mzs_pkg::EPS_BITS-1:0]  eps_q;
	mzs_pkg::dp_cmd_t              dp_cmd;
	logic signed [mzs_pkg::Z_BITS-1:0] z_score;

	// registers take a write in any cycle; software writes only while idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= mzs_pkg::WLEN_BITS'(64);
			eps_q  <= mzs_pkg::EPS_BITS'(1);
		end else if (cfg_valid) begin
			unique case (mzs_pkg::cfg_reg_t'(cfg_index))
				mzs_pkg::REG_WINDOW_LENGTH: wlen_q <= cfg_data[mzs_pkg::WLEN_BITS-1:0];
				mzs_pkg::REG_EPSILON:       eps_q  <= cfg_data[mzs_pkg::EPS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: one request at a time, result held until taken
	mzs_ctrl #(
		.MA_STEPS (CW),
		.MB_STEPS (SW),
		.SQ_STEPS (SW),
		.DV_STEPS (NW),
		.IW       (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_clear  (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.dp_cmd    (dp_cmd)
	);

	// ring, running sums, serial arithmetic and output register
	mzs_datapath #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.sample_in   ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
		.wlen        (wlen_q),
		.eps         (eps_q),
		.z_score     (z_score),
		.window_full (m_axis_tuser)
	);

	assign m_axis_tdata = z_score;

endmodule

@@ hdl/mzs_ctrl.sv @@
module mzs_ctrl #(
	parameter int unsigned MA_STEPS = 11,
	parameter int unsigned MB_STEPS = 27,
	parameter int unsigned SQ_STEPS = 27,
	parameter int unsigned DV_STEPS = 38,
	parameter int unsigned IW       = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_clear,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mzs_pkg::dp_cmd_t  dp_cmd
);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_SQR  = 13'b0000000000010,
		S_UPD  = 13'b0000000000100,
		S_MAI  = 13'b0000000001000,
		S_MAS  = 13'b0000000010000,
		S_MBI  = 13'b0000000100000,
		S_MBS  = 13'b0000001000000,
		S_SQI  = 13'b0000010000000,
		S_SQS  = 13'b0000100000000,
		S_PROD = 13'b0001000000000,
		S_DVI  = 13'b0010000000000,
		S_DVS  = 13'b0100000000000,
		S_FIN  = 13'b1000000000000
	} state_t;

	state_t        state_q, state_d;
	logic [IW-1:0] cnt_q, cnt_d;
	logic          out_valid_q;
	logic          load_out;
	logic          cnt_zero;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cnt_zero  = (cnt_q == '0);
	assign load_out  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		dp_cmd.op = mzs_pkg::OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dp_cmd.op = in_clear ? mzs_pkg::OP_CLEAR : mzs_pkg::OP_START;
					state_d   = in_clear ? S_FIN : S_SQR;
				end
			end
			S_SQR: begin
				dp_cmd.op = mzs_pkg::OP_SQUARE;
				state_d   = S_UPD;
			end
			S_UPD: begin
				dp_cmd.op = mzs_pkg::OP_UPDATE;
				state_d   = S_MAI;
			end
			S_MAI: begin
				dp_cmd.op = mzs_pkg::OP_MA_INIT;
				cnt_d     = IW'(MA_STEPS - 1);
				state_d   = S_MAS;
			end
			S_MAS: begin
				dp_cmd.op = mzs_pkg::OP_MA_STEP;
				cnt_d     = cnt_q - 1'b1;
				if (cnt_zero) state_d = S_MBI;
			end
			S_MBI: begin
				dp_cmd.op = mzs_pkg::OP_MB_INIT;
				cnt_d     = IW'(MB_STEPS - 1);
				state_d   = S_MBS;
			end
			S_MBS: begin
				dp_cmd.op = mzs_pkg::OP_MB_STEP;
				cnt_d     = cnt_q - 1'b1;
				if (cnt_zero) state_d = S_SQI;
			end
			S_SQI: begin
				dp_cmd.op = mzs_pkg::OP_SQ_INIT;
				cnt_d     = IW'(SQ_STEPS - 1);
				state_d   = S_SQS;
			end
			S_SQS: begin
				dp_cmd.op = mzs_pkg::OP_SQ_STEP;
				cnt_d     = cnt_q - 1'b1;
				if (cnt_zero) state_d = S_PROD;
			end
			S_PROD: begin
				dp_cmd.op = mzs_pkg::OP_PROD;
				state_d   = S_DVI;
			end
			S_DVI: begin
				dp_cmd.op = mzs_pkg::OP_DIV_INIT;
				cnt_d     = IW'(DV_STEPS - 1);
				state_d   = S_DVS;
			end
			S_DVS: begin
				dp_cmd.op = mzs_pkg::OP_DIV_STEP;
				cnt_d     = cnt_q - 1'b1;
				if (cnt_zero) state_d = S_FIN;
			end
			S_FIN: begin
				if (load_out) begin
					dp_cmd.op = mzs_pkg::OP_FINISH;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result shown without a finished request");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("pending result dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> (state_q != S_IDLE))
		else $error("accepted request not started");

endmodule

@@ hdl/mzs_datapath.sv @@
module mzs_datapath #(
	parameter int unsigned WINDOW_MAX  = 1024,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mzs_pkg::dp_cmd_t                     cmd,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	input  logic [mzs_pkg::WLEN_BITS-1:0]        wlen,
	input  logic [mzs_pkg::EPS_BITS-1:0]         eps,
	output logic signed [mzs_pkg::Z_BITS-1:0]    z_score,
	output logic                                 window_full
);

	localparam int unsigned SB   = SAMPLE_BITS;
	localparam int unsigned CW   = $clog2(WINDOW_MAX + 1);
	localparam int unsigned PW   = $clog2(WINDOW_MAX);
	localparam int unsigned SW   = SB + CW;
	localparam int unsigned QW   = 2 * SB + CW;
	localparam int unsigned VW   = 2 * SW;
	localparam int unsigned RW   = SW;
	localparam int unsigned NW   = SW + 1 + mzs_pkg::Z_FRAC_BITS;
	localparam int unsigned LW   = (CW > mzs_pkg::WLEN_BITS) ? CW : mzs_pkg::WLEN_BITS;
	localparam int unsigned EW   = mzs_pkg::EPS_BITS + CW;
	localparam int unsigned RSW  = RW + mzs_pkg::EPS_SCALE_BITS;
	localparam int unsigned CMPW = (EW > RSW) ? EW : RSW;

	logic signed [SB-1:0]  ring_mem [WINDOW_MAX];
	logic signed [SB-1:0]  rd_q;
	logic signed [SB-1:0]  x_q;
	logic                  drop_q;
	logic [2*SB-1:0]       oldsq_q, xsq_q;
	logic signed [SW-1:0]  sum_q;
	logic [QW-1:0]         sq_q;
	logic [CW-1:0]         count_q;
	logic [PW-1:0]         wp_q;
	logic [VW-1:0]         ma_q, acc_q, a_q, vsh_q;
	logic [SW-1:0]         mb_q;
	logic [RW:0]           rem_q;
	logic [RW-1:0]         root_q;
	logic [EW-1:0]         epsn_q;
	logic signed [SW-1:0]  nx_q;
	logic                  ok_q, neg_q;
	logic [NW-1:0]         dvd_q;
	logic signed [mzs_pkg::Z_BITS-1:0] z_q;
	logic                  full_q;

	logic [LW-1:0]         wlen_x;
	logic [CW-1:0]         len;
	logic [CW:0]           idx_t;
	logic [PW-1:0]         rd_idx;
	logic [SW-1:0]         sabs;
	logic [RW+2:0]         sq_r2, sq_trial;
	logic [RW:0]           dv_r2;
	logic signed [SW:0]    diff;
	logic [SW:0]           dabs;
	logic signed [CW+SB:0] nx_full;
	logic signed [2*SB-1:0] xsq_full, oldsq_full;
	logic [CMPW-1:0]       root_sc, epsn_x;
	logic                  full_now;
	logic signed [mzs_pkg::Z_BITS-1:0] z_sat;

	// effective window length: zero means one, clamp at the ring size
	always_comb begin
		wlen_x = LW'(wlen);
		if (wlen_x == '0)
			len = CW'(1);
		else if (wlen_x > LW'(WINDOW_MAX))
			len = CW'(WINDOW_MAX);
		else
			len = wlen_x[CW-1:0];
	end

	always_comb begin
		idx_t = (CW+1)'(wp_q) + (CW+1)'(WINDOW_MAX) - (CW+1)'(count_q);
		if (idx_t >= (CW+1)'(WINDOW_MAX))
			idx_t = idx_t - (CW+1)'(WINDOW_MAX);
		rd_idx = idx_t[PW-1:0];
	end

	assign sabs       = (sum_q < 0) ? SW'(-sum_q) : SW'(sum_q);
	assign sq_r2      = {rem_q, vsh_q[VW-1 -: 2]};
	assign sq_trial   = {1'b0, root_q, 2'b01};
	assign dv_r2      = {rem_q[RW-1:0], dvd_q[NW-1]};
	assign diff       = (SW+1)'(nx_q) - (SW+1)'(sum_q);
	assign dabs       = (diff < 0) ? (SW+1)'(-diff) : (SW+1)'(diff);
	assign nx_full    = (CW+SB+1)'($signed({1'b0, count_q})) * (CW+SB+1)'(x_q);
	assign xsq_full   = (2*SB)'(x_q) * (2*SB)'(x_q);
	assign oldsq_full = (2*SB)'(rd_q) * (2*SB)'(rd_q);
	assign root_sc    = CMPW'({root_q, {mzs_pkg::EPS_SCALE_BITS{1'b0}}});
	assign epsn_x     = CMPW'(epsn_q);
	assign full_now   = (count_q >= len);

	always_comb begin
		if (!ok_q)
			z_sat = '0;
		else if (neg_q)
			z_sat = (dvd_q > NW'(32768)) ? mzs_pkg::Z_NEG_MAX
				: -$signed(dvd_q[mzs_pkg::Z_BITS-1:0]);
		else
			z_sat = (dvd_q > NW'(32767)) ? mzs_pkg::Z_POS_MAX
				: $signed(dvd_q[mzs_pkg::Z_BITS-1:0]);
	end

	// ring: one read port, one write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.op == mzs_pkg::OP_START)
			rd_q <= ring_mem[rd_idx];
		if (cmd.op == mzs_pkg::OP_UPDATE)
			ring_mem[wp_q] <= x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sq_q    <= '0;
			count_q <= '0;
			wp_q    <= '0;
		end else begin
			case (cmd.op)
				mzs_pkg::OP_CLEAR: begin
					sum_q   <= '0;
					sq_q    <= '0;
					count_q <= '0;
					wp_q    <= '0;
				end
				mzs_pkg::OP_UPDATE: begin
					sum_q <= sum_q - (drop_q ? SW'(rd_q) : SW'(0)) + SW'(x_q);
					sq_q  <= sq_q - (drop_q ? QW'(oldsq_q) : QW'(0)) + QW'(xsq_q);
					if (!drop_q)
						count_q <= count_q + 1'b1;
					wp_q <= (wp_q == PW'(WINDOW_MAX - 1)) ? '0 : wp_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			mzs_pkg::OP_CLEAR: ok_q <= 1'b0;
			mzs_pkg::OP_START: begin
				x_q    <= sample_in;
				drop_q <= full_now;
			end
			mzs_pkg::OP_SQUARE: begin
				xsq_q   <= $unsigned(xsq_full);
				oldsq_q <= $unsigned(oldsq_full);
			end
			mzs_pkg::OP_MA_INIT: begin
				ma_q  <= VW'(sq_q);
				mb_q  <= SW'(count_q);
				acc_q <= '0;
			end
			mzs_pkg::OP_MA_STEP, mzs_pkg::OP_MB_STEP: begin
				if (mb_q[0])
					acc_q <= acc_q + ma_q;
				ma_q <= ma_q << 1;
				mb_q <= mb_q >> 1;
			end
			mzs_pkg::OP_MB_INIT: begin
				a_q   <= acc_q;
				ma_q  <= VW'(sabs);
				mb_q  <= sabs;
				acc_q <= '0;
			end
			mzs_pkg::OP_SQ_INIT: begin
				vsh_q  <= (acc_q > a_q) ? '0 : a_q - acc_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			mzs_pkg::OP_SQ_STEP: begin
				vsh_q <= vsh_q << 2;
				if (sq_r2 >= sq_trial) begin
					rem_q  <= (RW+1)'(sq_r2 - sq_trial);
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q  <= (RW+1)'(sq_r2);
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
			mzs_pkg::OP_PROD: begin
				epsn_q <= EW'(eps) * EW'(count_q);
				nx_q   <= nx_full[SW-1:0];
			end
			mzs_pkg::OP_DIV_INIT: begin
				ok_q  <= (root_q != '0) && (root_sc >= epsn_x);
				neg_q <= diff < 0;
				dvd_q <= {dabs, {mzs_pkg::Z_FRAC_BITS{1'b0}}};
				rem_q <= '0;
			end
			mzs_pkg::OP_DIV_STEP: begin
				if (dv_r2 >= {1'b0, root_q}) begin
					rem_q <= dv_r2 - {1'b0, root_q};
					dvd_q <= {dvd_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= dv_r2;
					dvd_q <= {dvd_q[NW-2:0], 1'b0};
				end
			end
			mzs_pkg::OP_FINISH: begin
				z_q    <= z_sat;
				full_q <= full_now;
			end
			default: ;
		endcase
	end

	assign z_score     = z_q;
	assign window_full = full_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(WINDOW_MAX))
		else $error("sample count beyond ring size");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == mzs_pkg::OP_CLEAR) |=> (sum_q == '0 && sq_q == '0 && count_q == '0))
		else $error("clear left state behind");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == mzs_pkg::OP_FINISH && !ok_q) |=> (z_q == '0))
		else $error("nonzero score below deviation floor");

endmodule
